>>> rtl/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg: shared types and helpers for the restart supervisor
// Holds the state, action and command codes, the configuration and result
// bundles, and the backoff and saturating-add functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned MS_W      = 31;
  localparam int unsigned FAIL_W    = 8;
  localparam int unsigned HSEC_W    = 20;
  localparam int unsigned HMS_W     = 30;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned EXP_CAP   = 30;
  localparam int unsigned MS_PER_SEC = 1000;

  // Reset values of the configuration registers.
  localparam logic [MS_W-1:0]   BASE_RST    = 31'd10000;
  localparam logic [MS_W-1:0]   MAX_RST     = 31'd300000;
  localparam logic [FAIL_W-1:0] RETRY_RST   = 8'd5;
  localparam logic [HMS_W-1:0]  HEALTHY_RST = 30'd600000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE    = 3'd0,
    CFG_MAX     = 3'd1,
    CFG_RETRIES = 3'd2,
    CFG_HEALTHY = 3'd3,
    CFG_AUTO    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_STOPPING = 3'd3,
    ST_CRASHED  = 3'd4,
    ST_FAILED   = 3'd5
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_MARK   = 3'd3,
    ACT_SCHED  = 3'd4,
    ACT_GIVEUP = 3'd5,
    ACT_RESET  = 3'd6,
    ACT_PARK   = 3'd7
  } action_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_REQ_START  = 3'd1,
    CMD_REQ_STOP   = 3'd2,
    CMD_STARTED_OK = 3'd3,
    CMD_START_FAIL = 3'd4,
    CMD_STOPPED    = 3'd5
  } cmd_t;

  // Configuration as seen by the decision logic; the healthy uptime is kept
  // in milliseconds so that no division is needed on the uptime.
  typedef struct packed {
    logic [MS_W-1:0]   base_ms;
    logic [MS_W-1:0]   max_ms;
    logic [FAIL_W-1:0] max_retries;
    logic [HMS_W-1:0]  healthy_ms;
    logic              auto_restart;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    state_t            actual_state;
    logic              desired_run;
    logic [FAIL_W-1:0] failure_count;
    logic [MS_W-1:0]   restart_wait_ms;
  } result_t;

  // Restart delay: base shifted by the capped failure count, saturated at max.
  function automatic logic [MS_W-1:0] backoff_for(input logic [MS_W-1:0] base_ms,
                                                  input logic [MS_W-1:0] max_ms,
                                                  input logic [FAIL_W-1:0] failures);
    logic [4:0]             exp_v;
    logic [MS_W+EXP_CAP-1:0] shifted;
    logic [MS_W-1:0]        res;
    exp_v = (failures > FAIL_W'(EXP_CAP)) ? 5'(EXP_CAP) : failures[4:0];
    shifted = (MS_W+EXP_CAP)'(base_ms) << exp_v;
    if (base_ms == '0) begin
      res = '0;
    end else if (shifted >= (MS_W+EXP_CAP)'(max_ms)) begin
      res = max_ms;
    end else begin
      res = shifted[MS_W-1:0];
    end
    return res;
  endfunction

  // Deadline addition that saturates at the top of the time range.
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                               input logic [MS_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + (TIME_W+1)'(b);
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  function automatic logic [FAIL_W-1:0] inc_sat(input logic [FAIL_W-1:0] f);
    return (f == {FAIL_W{1'b1}}) ? f : f + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/restart_supervisor_with_backoff_unit.sv
// ----------------------------------------------------------------------------
// restart_supervisor_with_backoff_unit: process restart supervisor
// Top level with input register, decision core, result register and
// configuration registers.
// ----------------------------------------------------------------------------
// Each accepted transaction produces exactly one result. The block takes one
// transaction per cycle while the output is not stalled: it is registered on
// input, evaluated against the supervisor state by combinational logic, and
// loaded into the result register when it leaves the input register, which
// raises out_valid. The rate is set by the state update loop in the core.
// While a result waits in the result register, the input register still
// takes one transaction if it is empty; with both registers full, in_ready
// follows out_ready. Configuration writes are taken in any cycle and should
// be made only while no transaction is outstanding; the healthy uptime
// register is given in seconds. There is no clearing pass after reset.
`default_nettype none

module restart_supervisor_with_backoff_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rsb_pkg::CMD_W-1:0]         in_command,
  input  wire logic                              in_process_alive,
  input  wire logic                              in_updating,
  input  wire logic [rsb_pkg::TIME_W-1:0]        in_now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_action,
  output logic [2:0]                             out_actual_state,
  output logic                                   out_desired_run,
  output logic [rsb_pkg::FAIL_W-1:0]             out_failure_count,
  output logic [rsb_pkg::MS_W-1:0]               out_restart_wait_ms,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsb_pkg::MS_W-1:0]          cfg_data
);
  import rsb_pkg::*;

  logic               s1_valid_r;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic               s1_alive_r;
  logic               s1_upd_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               out_valid_r;
  result_t            out_res_r;
  logic               advance;
  logic               fire;
  logic               in_fire;
  cfg_t               cfg;
  result_t            res;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rsb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsb_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .cmd    (s1_cmd_r),
    .alive  (s1_alive_r),
    .upd    (s1_upd_r),
    .now_ms (s1_now_r),
    .cfg    (cfg),
    .res    (res)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_command;
      s1_alive_r <= in_process_alive;
      s1_upd_r   <= in_updating;
      s1_now_r   <= in_now_ms;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_res_r.action;
  assign out_actual_state    = out_res_r.actual_state;
  assign out_desired_run     = out_res_r.desired_run;
  assign out_failure_count   = out_res_r.failure_count;
  assign out_restart_wait_ms = out_res_r.restart_wait_ms;

endmodule

`default_nettype wire

>>> rtl/rsb_cfg.sv
// ----------------------------------------------------------------------------
// rsb_cfg: configuration register file
// Holds the five supervisor settings; the healthy uptime is converted from
// seconds to milliseconds when it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [rsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rsb_pkg::MS_W-1:0]        cfg_data,
  output rsb_pkg::cfg_t                        cfg
);
  import rsb_pkg::*;

  cfg_t               cfg_r;
  logic [HMS_W-1:0]   healthy_ms;

  // Seconds to milliseconds, one small multiply on the write path.
  assign healthy_ms = HMS_W'(cfg_data[HSEC_W-1:0]) * HMS_W'(MS_PER_SEC);

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_ms      <= BASE_RST;
      cfg_r.max_ms       <= MAX_RST;
      cfg_r.max_retries  <= RETRY_RST;
      cfg_r.healthy_ms   <= HEALTHY_RST;
      cfg_r.auto_restart <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE:    cfg_r.base_ms      <= cfg_data;
        CFG_MAX:     cfg_r.max_ms       <= cfg_data;
        CFG_RETRIES: cfg_r.max_retries  <= cfg_data[FAIL_W-1:0];
        CFG_HEALTHY: cfg_r.healthy_ms   <= healthy_ms;
        CFG_AUTO:    cfg_r.auto_restart <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/rsb_core.sv
// ----------------------------------------------------------------------------
// rsb_core: supervisor state and per-transaction decision logic
// Evaluates one command against the current state, produces the result and
// commits the new state when the transaction moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               fire,
  input  wire logic [rsb_pkg::CMD_W-1:0]          cmd,
  input  wire logic                               alive,
  input  wire logic                               upd,
  input  wire logic [rsb_pkg::TIME_W-1:0]         now_ms,
  input  wire rsb_pkg::cfg_t                      cfg,
  output rsb_pkg::result_t                        res
);
  import rsb_pkg::*;

  state_t              mode_r, mode_nxt;
  logic                want_r, want_nxt;
  logic                busy_r, busy_nxt;
  logic [FAIL_W-1:0]   fail_r, fail_nxt;
  logic [TIME_W-1:0]   started_r, started_nxt;
  logic [TIME_W-1:0]   deadline_r, deadline_nxt;

  logic [TIME_W:0]     up_diff;
  logic                healthy;
  logic [MS_W-1:0]     wait_cur;
  logic                give_up;
  action_t             tick_act;
  action_t             act;
  logic [MS_W-1:0]     wait_ms;

  // Uptime check without a divide: floor(d / 1000) >= h exactly when d >= 1000 h.
  assign up_diff = {1'b0, now_ms} - {1'b0, started_r};
  assign healthy = (started_r != '0) && !up_diff[TIME_W] &&
                   (up_diff[TIME_W-1:0] >= TIME_W'(cfg.healthy_ms));

  assign wait_cur = backoff_for(cfg.base_ms, cfg.max_ms, fail_r);
  assign give_up  = ({1'b0, fail_r} + 1'b1) >= {1'b0, cfg.max_retries};

  // Supervisory decision taken by a tick.
  always_comb begin
    tick_act = ACT_NONE;
    if (!upd && !busy_r) begin
      if (want_r) begin
        unique case (mode_r)
          ST_STOPPED: tick_act = alive ? ACT_NONE : ACT_START;
          ST_CRASHED: tick_act = (!alive && now_ms >= deadline_r) ? ACT_START : ACT_NONE;
          ST_RUNNING: begin
            if (alive) begin
              tick_act = (healthy && fail_r != '0) ? ACT_RESET : ACT_NONE;
            end else begin
              tick_act = give_up ? ACT_GIVEUP : ACT_SCHED;
            end
          end
          default: tick_act = ACT_NONE;
        endcase
      end else if (mode_r == ST_RUNNING) begin
        tick_act = alive ? ACT_STOP : ACT_MARK;
      end
      if ((tick_act == ACT_SCHED || tick_act == ACT_GIVEUP) && !cfg.auto_restart) begin
        tick_act = ACT_PARK;
      end
    end
  end

  // Next state and result for the transaction in hand.
  always_comb begin
    mode_nxt     = mode_r;
    want_nxt     = want_r;
    busy_nxt     = busy_r;
    fail_nxt     = fail_r;
    started_nxt  = started_r;
    deadline_nxt = deadline_r;
    act          = ACT_NONE;
    wait_ms      = '0;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        act = tick_act;
        unique case (tick_act)
          ACT_START: begin
            busy_nxt = 1'b1;
            mode_nxt = ST_STARTING;
          end
          ACT_STOP: begin
            busy_nxt = 1'b1;
            mode_nxt = ST_STOPPING;
          end
          ACT_MARK: mode_nxt = ST_STOPPED;
          ACT_SCHED: begin
            wait_ms      = wait_cur;
            fail_nxt     = inc_sat(fail_r);
            mode_nxt     = ST_CRASHED;
            deadline_nxt = add_sat(now_ms, wait_cur);
          end
          ACT_GIVEUP: begin
            fail_nxt = inc_sat(fail_r);
            mode_nxt = ST_FAILED;
          end
          ACT_RESET: fail_nxt = '0;
          ACT_PARK: begin
            mode_nxt = ST_CRASHED;
            want_nxt = 1'b0;
          end
          ACT_NONE: begin
          end
        endcase
      end
      CMD_REQ_START: begin
        want_nxt     = 1'b1;
        fail_nxt     = '0;
        deadline_nxt = '0;
        if (mode_r == ST_FAILED || mode_r == ST_CRASHED) begin
          mode_nxt = ST_STOPPED;
        end
      end
      CMD_REQ_STOP: want_nxt = 1'b0;
      CMD_STARTED_OK: begin
        if (busy_r && mode_r == ST_STARTING) begin
          mode_nxt    = ST_RUNNING;
          started_nxt = now_ms;
          busy_nxt    = 1'b0;
        end
      end
      CMD_START_FAIL: begin
        if (busy_r && mode_r == ST_STARTING) begin
          busy_nxt = 1'b0;
          fail_nxt = inc_sat(fail_r);
          // A startup failure while any failure is already counted gives up at once.
          if (fail_r != '0) begin
            mode_nxt = ST_FAILED;
            act      = ACT_GIVEUP;
          end else begin
            wait_ms      = wait_cur;
            mode_nxt     = ST_CRASHED;
            deadline_nxt = add_sat(now_ms, wait_cur);
            act          = ACT_SCHED;
          end
        end
      end
      CMD_STOPPED: begin
        if (busy_r && mode_r == ST_STOPPING) begin
          mode_nxt = ST_STOPPED;
          busy_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // State commits only when the transaction leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ST_STOPPED;
      want_r     <= 1'b0;
      busy_r     <= 1'b0;
      fail_r     <= '0;
      started_r  <= '0;
      deadline_r <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      want_r     <= want_nxt;
      busy_r     <= busy_nxt;
      fail_r     <= fail_nxt;
      started_r  <= started_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  assign res.action          = act;
  assign res.actual_state    = mode_nxt;
  assign res.desired_run     = want_nxt;
  assign res.failure_count   = fail_nxt;
  assign res.restart_wait_ms = wait_ms;

  // A worker is in flight only while starting or stopping.
  a_busy_mode: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mode_r == ST_STARTING || mode_r == ST_STOPPING))
    else $error("worker busy outside starting or stopping");

  // A restart delay is reported only with a scheduled restart.
  a_wait_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_ms != '0) |-> (act == ACT_SCHED))
    else $error("restart wait without scheduled restart");

  // The failure count falls only on a reset of failures or a start request.
  a_fail_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && fail_nxt < fail_r) |-> (act == ACT_RESET || cmd_t'(cmd) == CMD_REQ_START))
    else $error("failure count dropped unexpectedly");

  // A start action always leaves a starting worker behind.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && act == ACT_START) |=> (busy_r && mode_r == ST_STARTING))
    else $error("start issued without starting worker");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the restart supervisor with backoff
// A scripted sequence walks the basic lifecycle from reset: start, crash,
// backoff restart, give-up, healthy reset, stop, mark stopped and deadline
// saturation. It is followed by phases of random traffic under several
// register settings. Most of that traffic follows the supervisor's current
// state, and the rest is noise. Every result is checked in order against a
// behavioral model of the supervisor kept in this file.
// ----------------------------------------------------------------------------

module tb_top;
  import rsb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SCRIPT_LEN   = 28;
  localparam int PHASES       = 7;

  localparam logic [TIME_W-1:0]    T_MAX           = '1;
  localparam logic [HSEC_W-1:0]    HEALTHY_SEC_RST = HSEC_W'(HEALTHY_RST / MS_PER_SEC);
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO    = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI    = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              alive;
    logic              upd;
    logic [TIME_W-1:0] now;
  } stim_t;

  typedef struct packed {
    stim_t   stim;
    logic    typed;
    result_t res;
  } script_row_t;

  // Register values and the shape of the random traffic for one phase.
  typedef struct {
    logic [MS_W-1:0]   base_ms;
    logic [MS_W-1:0]   max_ms;
    logic [FAIL_W-1:0] retries;
    logic [HSEC_W-1:0] healthy_s;
    logic              auto_on;
    int                n_items;
    int                noise_pct;
    int                crash_pct;
    int                fail_pct;
    int                heal_pct;
    bit                churn;
  } phase_t;

  localparam result_t IDLE_RES = '{ACT_NONE, ST_STOPPED, 1'b0, 8'd0, 31'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = '0;
  logic                 in_process_alive = 1'b0;
  logic                 in_updating = 1'b0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_action;
  logic [2:0]           out_actual_state;
  logic                 out_desired_run;
  logic [FAIL_W-1:0]    out_failure_count;
  logic [MS_W-1:0]      out_restart_wait_ms;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_data = '0;

  // Model copy of the supervisor state and its registers.
  state_t            proc_mode = ST_STOPPED;
  logic              proc_want = 1'b0;
  logic              worker_on = 1'b0;
  logic [FAIL_W-1:0] fail_cnt = '0;
  logic [TIME_W-1:0] up_since_ms = '0;
  logic [TIME_W-1:0] retry_at_ms = '0;
  logic [MS_W-1:0]   set_base_ms = BASE_RST;
  logic [MS_W-1:0]   set_max_ms = MAX_RST;
  logic [FAIL_W-1:0] set_retries = RETRY_RST;
  logic [HSEC_W-1:0] set_healthy_s = HEALTHY_SEC_RST;
  logic              set_auto = 1'b1;

  result_t           pending_outcomes[$];
  logic [TIME_W-1:0] now_cur = '0;
  int                cycles = 0;
  int                errors = 0;
  int                stall_left = 0;

  // Lifecycle walk from reset under the reset register values.
  script_row_t script [SCRIPT_LEN] = '{
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd0},         1'b1, IDLE_RES},
    '{'{CMD_SPARE_LO,   1'b1, 1'b1, T_MAX},         1'b1, IDLE_RES},
    '{'{CMD_STARTED_OK, 1'b1, 1'b0, 48'd100},       1'b1, IDLE_RES},
    '{'{CMD_REQ_START,  1'b0, 1'b0, 48'd200},       1'b1,
      '{ACT_NONE, ST_STOPPED, 1'b1, 8'd0, 31'd0}},
    '{'{CMD_TICK,       1'b0, 1'b1, 48'd300},       1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd400},       1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd500},       1'b0, IDLE_RES},
    '{'{CMD_START_FAIL, 1'b0, 1'b0, 48'd1000},      1'b1,
      '{ACT_SCHED, ST_CRASHED, 1'b1, 8'd1, 31'd10000}},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd11000},     1'b0, IDLE_RES},
    '{'{CMD_START_FAIL, 1'b0, 1'b0, 48'd12000},     1'b1,
      '{ACT_GIVEUP, ST_FAILED, 1'b1, 8'd2, 31'd0}},
    '{'{CMD_REQ_START,  1'b0, 1'b0, 48'd13000},     1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd13000},     1'b0, IDLE_RES},
    '{'{CMD_STARTED_OK, 1'b1, 1'b0, 48'd14000},     1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd15000},     1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd25000},     1'b0, IDLE_RES},
    '{'{CMD_STARTED_OK, 1'b1, 1'b0, 48'd26000},     1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b1, 1'b0, 48'd626000},    1'b0, IDLE_RES},
    '{'{CMD_REQ_STOP,   1'b1, 1'b0, 48'd627000},    1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b1, 1'b0, 48'd628000},    1'b0, IDLE_RES},
    '{'{CMD_STOPPED,    1'b1, 1'b0, 48'd629000},    1'b0, IDLE_RES},
    '{'{CMD_REQ_START,  1'b0, 1'b0, 48'd630000},    1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, 48'd630000},    1'b0, IDLE_RES},
    '{'{CMD_STARTED_OK, 1'b1, 1'b0, T_MAX - 48'd500}, 1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, T_MAX},         1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, T_MAX},         1'b0, IDLE_RES},
    '{'{CMD_STARTED_OK, 1'b1, 1'b0, T_MAX},         1'b0, IDLE_RES},
    '{'{CMD_REQ_STOP,   1'b1, 1'b0, T_MAX},         1'b0, IDLE_RES},
    '{'{CMD_TICK,       1'b0, 1'b0, T_MAX},         1'b0, IDLE_RES}
  };

  restart_supervisor_with_backoff_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_process_alive    (in_process_alive),
    .in_updating         (in_updating),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_actual_state    (out_actual_state),
    .out_desired_run     (out_desired_run),
    .out_failure_count   (out_failure_count),
    .out_restart_wait_ms (out_restart_wait_ms),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  // Restart delay for a given count of earlier failures.
  function automatic logic [MS_W-1:0] backoff_delay(input logic [FAIL_W-1:0] f);
    logic [63:0] v;
    int unsigned e;
    if (set_base_ms == '0) return '0;
    e = (f > FAIL_W'(EXP_CAP)) ? EXP_CAP : int'(f);
    v = 64'(set_base_ms) << e;
    return (v >= 64'(set_max_ms)) ? set_max_ms : v[MS_W-1:0];
  endfunction

  function automatic logic [FAIL_W-1:0] bump(input logic [FAIL_W-1:0] f);
    return (f == '1) ? f : f + 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] deadline_after(input logic [TIME_W-1:0] now,
                                                       input logic [MS_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, now} + (TIME_W+1)'(d);
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  // Applies one command to the model state and returns the expected result.
  function automatic result_t apply_command(input stim_t s);
    result_t         r;
    action_t         act;
    logic [MS_W-1:0] delay_ms;
    logic [63:0]     up_s;
    act = ACT_NONE;
    delay_ms = '0;
    up_s = '0;
    case (s.cmd)
      CMD_TICK: begin
        if (!s.upd && !worker_on) begin
          if (up_since_ms != '0 && s.now >= up_since_ms)
            up_s = 64'(s.now - up_since_ms) / MS_PER_SEC;
          if (proc_want) begin
            case (proc_mode)
              ST_STOPPED: act = s.alive ? ACT_NONE : ACT_START;
              ST_CRASHED: act = (!s.alive && s.now >= retry_at_ms) ? ACT_START : ACT_NONE;
              ST_RUNNING: begin
                if (s.alive)
                  act = (up_s >= 64'(set_healthy_s) && fail_cnt != '0) ? ACT_RESET : ACT_NONE;
                else
                  act = ({1'b0, fail_cnt} + 9'd1 >= {1'b0, set_retries}) ? ACT_GIVEUP
                                                                          : ACT_SCHED;
              end
              default: act = ACT_NONE;
            endcase
          end else if (proc_mode == ST_RUNNING) begin
            act = s.alive ? ACT_STOP : ACT_MARK;
          end
          // With auto restart off a crash is parked instead of handled.
          if ((act == ACT_SCHED || act == ACT_GIVEUP) && !set_auto) begin
            act = ACT_PARK;
            proc_mode = ST_CRASHED;
            proc_want = 1'b0;
          end
          case (act)
            ACT_START: begin
              worker_on = 1'b1;
              proc_mode = ST_STARTING;
            end
            ACT_STOP: begin
              worker_on = 1'b1;
              proc_mode = ST_STOPPING;
            end
            ACT_MARK: proc_mode = ST_STOPPED;
            ACT_SCHED: begin
              delay_ms = backoff_delay(fail_cnt);
              fail_cnt = bump(fail_cnt);
              proc_mode = ST_CRASHED;
              retry_at_ms = deadline_after(s.now, delay_ms);
            end
            ACT_GIVEUP: begin
              fail_cnt = bump(fail_cnt);
              proc_mode = ST_FAILED;
            end
            ACT_RESET: fail_cnt = '0;
            default: ;
          endcase
        end
      end
      CMD_REQ_START: begin
        proc_want = 1'b1;
        fail_cnt = '0;
        retry_at_ms = '0;
        if (proc_mode == ST_FAILED || proc_mode == ST_CRASHED) proc_mode = ST_STOPPED;
      end
      CMD_REQ_STOP: proc_want = 1'b0;
      CMD_STARTED_OK: begin
        if (worker_on && proc_mode == ST_STARTING) begin
          proc_mode = ST_RUNNING;
          up_since_ms = s.now;
          worker_on = 1'b0;
        end
      end
      CMD_START_FAIL: begin
        if (worker_on && proc_mode == ST_STARTING) begin
          worker_on = 1'b0;
          delay_ms = backoff_delay(fail_cnt);
          fail_cnt = bump(fail_cnt);
          if (fail_cnt >= FAIL_W'(2)) begin
            delay_ms = '0;
            proc_mode = ST_FAILED;
            act = ACT_GIVEUP;
          end else begin
            proc_mode = ST_CRASHED;
            retry_at_ms = deadline_after(s.now, delay_ms);
            act = ACT_SCHED;
          end
        end
      end
      CMD_STOPPED: begin
        if (worker_on && proc_mode == ST_STOPPING) begin
          proc_mode = ST_STOPPED;
          worker_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.action = act;
    r.actual_state = proc_mode;
    r.desired_run = proc_want;
    r.failure_count = fail_cnt;
    r.restart_wait_ms = delay_ms;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, a few long, and none
  // at all in a recurring window of the run.
  function automatic int idle_len();
    int r;
    if ((cycles % 1024) < 160) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Next random command: usually the one the current state is waiting for,
  // sometimes noise.
  function automatic stim_t make_stim(input phase_t ph);
    stim_t s;
    now_cur = now_cur + 48'($urandom_range(0, 2000));
    s.cmd = CMD_TICK;
    s.alive = 1'b0;
    s.upd = 1'b0;
    s.now = now_cur;
    if ($urandom_range(0, 99) < ph.noise_pct) begin
      s.alive = 1'($urandom_range(0, 1));
      if (ph.churn) begin
        s.cmd = CMD_W'($urandom_range(0, 7));
        s.upd = 1'($urandom_range(0, 1));
      end else begin
        // No noise that would clear the failure count in this phase.
        s.cmd = $urandom_range(0, 1) ? CMD_TICK
                                     : CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        s.upd = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) s.now = TIME_W'({$urandom, $urandom});
    end else if (worker_on) begin
      if (proc_mode == ST_STARTING) begin
        s.cmd = ($urandom_range(0, 99) < ph.fail_pct) ? CMD_START_FAIL : CMD_STARTED_OK;
        s.alive = 1'b1;
      end else begin
        s.cmd = CMD_STOPPED;
      end
    end else if (ph.churn && $urandom_range(0, 99) < 5) begin
      s.cmd = $urandom_range(0, 1) ? CMD_REQ_START : CMD_REQ_STOP;
    end else if (!proc_want) begin
      if (proc_mode == ST_RUNNING) s.alive = 1'($urandom_range(0, 1));
      else s.cmd = CMD_REQ_START;
    end else begin
      case (proc_mode)
        ST_RUNNING: begin
          if ($urandom_range(0, 99) < ph.crash_pct) begin
            s.alive = 1'b0;
          end else begin
            s.alive = 1'b1;
            if ($urandom_range(0, 99) < ph.heal_pct) begin
              s.now = up_since_ms + 48'(set_healthy_s) * 48'(MS_PER_SEC)
                      + 48'($urandom_range(0, 1500));
              now_cur = s.now;
            end
          end
        end
        ST_CRASHED: begin
          if (ph.churn && $urandom_range(0, 9) == 0) s.alive = 1'b1;
          if ($urandom_range(0, 9) < 8) begin
            s.now = retry_at_ms + 48'($urandom_range(0, 2));
            now_cur = s.now;
          end
        end
        ST_FAILED: s.cmd = CMD_REQ_START;
        default: if ($urandom_range(0, 9) == 0) s.alive = 1'b1;
      endcase
    end
    return s;
  endfunction

  // Sends one transaction and records its expected result on acceptance.
  task automatic put_item(input stim_t s, input logic typed, input result_t typed_res);
    result_t predicted;
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= s.cmd;
    in_process_alive <= s.alive;
    in_updating <= s.upd;
    in_now_ms <= s.now;
    do @(posedge clk); while (!in_ready);
    predicted = apply_command(s);
    if (typed) predicted = typed_res;
    pending_outcomes = {pending_outcomes, predicted};
  endtask

  // One register write transaction; the model register follows on acceptance.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE:    set_base_ms = data;
      CFG_MAX:     set_max_ms = data;
      CFG_RETRIES: set_retries = data[FAIL_W-1:0];
      CFG_HEALTHY: set_healthy_s = data[HSEC_W-1:0];
      CFG_AUTO:    set_auto = data[0];
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] got_v);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // Result side: checks each accepted result and stalls at random.
  always @(posedge clk) begin : result_monitor
    result_t exp_r;
    int n;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("unrequested result, action", '0, out_action);
      end else begin
        exp_r = pending_outcomes.pop_front();
        if (out_action !== exp_r.action)
          note_mismatch("action", exp_r.action, out_action);
        if (out_actual_state !== exp_r.actual_state)
          note_mismatch("actual_state", exp_r.actual_state, out_actual_state);
        if (out_desired_run !== exp_r.desired_run)
          note_mismatch("desired_run", exp_r.desired_run, out_desired_run);
        if (out_failure_count !== exp_r.failure_count)
          note_mismatch("failure_count", exp_r.failure_count, out_failure_count);
        if (out_restart_wait_ms !== exp_r.restart_wait_ms)
          note_mismatch("restart_wait_ms", exp_r.restart_wait_ms, out_restart_wait_ms);
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      n = idle_len();
      out_ready <= (n == 0);
      if (n > 0) stall_left <= n - 1;
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("restart_supervisor_with_backoff_unit test failed");
      $finish;
    end
  end

  // Main sequence: reset, scripted walk, then random phases.
  initial begin
    phase_t ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      put_item(script[i].stim, script[i].typed, script[i].res);

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only once the block has gone idle.
      in_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);

      case (p)
        0: ph = '{31'd10000, 31'd300000, 8'd5, 20'd600, 1'b1, 100, 12, 30, 25, 30, 1'b1};
        1: ph = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 20'hF_FFFF, 1'b1,
                  80, 12, 30, 25, 30, 1'b1};
        2: ph = '{31'd0, 31'd0, 8'd0, 20'd0, 1'b0, 100, 12, 35, 25, 30, 1'b1};
        // Long crash loop: drives the failure count past the exponent cap
        // and up to its top value.
        3: ph = '{31'd1, 31'h7FFF_FFFF, 8'hFF, 20'hF_FFFF, 1'b1,
                  1050, 3, 100, 0, 0, 1'b0};
        default: ph = '{31'($urandom_range(0, 50000)), 31'($urandom_range(0, 2000000)),
                        8'($urandom_range(0, 8)), 20'($urandom_range(0, 60)),
                        1'($urandom_range(0, 1)), 40, 12, 30, 25, 30, 1'b1};
      endcase

      write_reg(CFG_BASE, ph.base_ms);
      write_reg(CFG_MAX, ph.max_ms);
      write_reg(CFG_RETRIES, {23'($urandom), ph.retries});
      write_reg(CFG_HEALTHY, {11'($urandom), ph.healthy_s});
      write_reg(CFG_AUTO, {30'($urandom), ph.auto_on});
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), MS_W'($urandom));
      cfg_valid <= 1'b0;

      if (p == 3) now_cur = TIME_W'($urandom_range(0, 1000));
      else if ($urandom_range(0, 3) == 0) now_cur = T_MAX - TIME_W'($urandom_range(0, 100000));
      else now_cur = TIME_W'({$urandom, $urandom});

      for (int k = 0; k < ph.n_items; k++) put_item(make_stim(ph), 1'b0, IDLE_RES);
    end

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("restart_supervisor_with_backoff_unit test passed");
    else
      $display("restart_supervisor_with_backoff_unit test failed");
    $finish;
  end

endmodule
